>>> design/drfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drfs_pkg: shared types and constants of the rectangle fill sequencer
// Command codes, sequence step codes and the result word bundle.
// ----------------------------------------------------------------------------
package drfs_pkg;

    localparam logic [7:0] CMD_COLUMN   = 8'h2A;
    localparam logic [7:0] CMD_PAGE     = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] t_step;

    // sequence positions
    localparam t_step STEP_COL_CMD  = 4'd0;
    localparam t_step STEP_Y_FIRST  = 4'd1;
    localparam t_step STEP_Y_LAST   = 4'd4;
    localparam t_step STEP_PAGE_CMD = 4'd5;
    localparam t_step STEP_X_FIRST  = 4'd6;
    localparam t_step STEP_X_LAST   = 4'd9;
    localparam t_step STEP_PIXEL    = 4'd11;

    // address word order within a group of four
    localparam logic [1:0] AW_START_HI = 2'd0;
    localparam logic [1:0] AW_START_LO = 2'd1;
    localparam logic [1:0] AW_END_HI   = 2'd2;
    localparam logic [1:0] AW_END_LO   = 2'd3;

    localparam logic ACT_START   = 1'b0;

    typedef struct packed {
        logic        word_valid;
        logic        is_data;
        logic [15:0] bus_word;
        logic        last_word;
    } t_word;

endpackage : drfs_pkg
`default_nettype wire

>>> design/drfs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drfs_core: sequence state and bus word generation
// Holds the latched rectangle and position; builds one word per item.
// ----------------------------------------------------------------------------
module drfs_core
    import drfs_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_action,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_width,
    input  wire logic [COORD_BITS-1:0] i_height,
    input  wire logic [15:0]           i_colour,
    output t_word                      o_word
);

    logic                  r_busy, n_busy;
    t_step                 r_step, n_step;
    logic [COORD_BITS-1:0] r_x, n_x, r_y, n_y, r_w, n_w, r_h, n_h;
    logic [COORD_BITS-1:0] r_row, n_row, r_col, n_col;
    logic [15:0]           r_colour, n_colour;

    logic [COORD_BITS-1:0] a_start, a_span;
    logic [15:0]           a_sum;
    logic [15:0]           a_begin, a_end, a_word;
    logic [1:0]            a_sel;
    logic                  is_y_grp;

    // address data words of the current group; the end address wraps at 16 bits
    always_comb begin
        is_y_grp = (r_step <= STEP_Y_LAST);
        a_start  = is_y_grp ? r_y : r_x;
        a_span   = is_y_grp ? r_h : r_w;
        a_sel    = is_y_grp ? 2'(r_step - STEP_Y_FIRST) : 2'(r_step - STEP_X_FIRST);
        a_sum    = 16'(a_start) + 16'(a_span);
        a_begin  = 16'(a_start);
        a_end    = a_sum;
        unique case (a_sel)
            AW_START_HI: a_word = {8'h00, a_begin[15:8]};
            AW_START_LO: a_word = a_begin;
            AW_END_HI:   a_word = {8'h00, a_end[15:8]};
            AW_END_LO:   a_word = a_end;
            default:     a_word = a_end;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_x      = r_x;
        n_y      = r_y;
        n_w      = r_w;
        n_h      = r_h;
        n_row    = r_row;
        n_col    = r_col;
        n_colour = r_colour;
        o_word   = '0;
        if (i_action == ACT_START) begin
            n_x      = i_start_x;
            n_y      = i_start_y;
            n_w      = i_width;
            n_h      = i_height;
            n_colour = i_colour;
            n_row    = '0;
            n_col    = '0;
            n_busy   = 1'b1;
            n_step   = STEP_Y_FIRST;
            o_word   = '{word_valid: 1'b1, is_data: 1'b0,
                         bus_word: {8'h00, CMD_COLUMN}, last_word: 1'b0};
        end else if (r_busy) begin
            o_word.word_valid = 1'b1;
            if (r_step < STEP_PIXEL) begin
                n_step = r_step + 4'd1;
                priority if (r_step == STEP_COL_CMD) begin
                    o_word.bus_word = {8'h00, CMD_COLUMN};
                end else if (r_step == STEP_PAGE_CMD) begin
                    o_word.bus_word = {8'h00, CMD_PAGE};
                end else if (r_step > STEP_X_LAST) begin
                    o_word.bus_word = {8'h00, CMD_MEMWRITE};
                end else begin
                    o_word.is_data  = 1'b1;
                    o_word.bus_word = a_word;
                end
            end else begin
                o_word.is_data  = 1'b1;
                o_word.bus_word = r_colour;
                if (r_col == r_w && r_row == r_h) begin
                    o_word.last_word = 1'b1;
                    n_busy = 1'b0;
                    n_step = STEP_COL_CMD;
                    n_row  = '0;
                    n_col  = '0;
                end else if (r_col == r_w) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= STEP_COL_CMD;
            r_x      <= '0;
            r_y      <= '0;
            r_w      <= '0;
            r_h      <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_colour <= '0;
        end else if (i_accept) begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_x      <= n_x;
            r_y      <= n_y;
            r_w      <= n_w;
            r_h      <= n_h;
            r_row    <= n_row;
            r_col    <= n_col;
            r_colour <= n_colour;
        end
    end

endmodule : drfs_core
`default_nettype wire

>>> design/display_rect_fill_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_rect_fill_sequencer: bus word sequencer for a rectangle fill
// Emits address commands, memory write and RGB565 pixel words of a fill.
// ----------------------------------------------------------------------------
// One item in, one result item out, one item per cycle sustained while the
// output is not stalled. A start item (action 0) latches the rectangle
// and colour and yields the column address command; each advance item
// (action 1) yields the next word: four column address data words, page
// address command, four page address data words, memory write command,
// then (height+1)*(width+1) pixel words, the final one flagged by last_word.
// An advance while idle yields a result with all fields zero. The result
// is registered at acceptance in a single output register; a new item is
// taken whenever that register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module display_rect_fill_sequencer
    import drfs_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_width,
    input  wire logic [COORD_BITS-1:0] i_height,
    input  wire logic [4:0]            i_red,
    input  wire logic [5:0]            i_green,
    input  wire logic [4:0]            i_blue,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_word_valid,
    output logic                       o_is_data,
    output logic [15:0]                o_bus_word,
    output logic                       o_last_word
);

    logic  accept;
    t_word step_word;
    logic  r_out_valid;
    t_word r_out;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    drfs_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (i_action),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_width   (i_width),
        .i_height  (i_height),
        .i_colour  ({i_red, i_green, i_blue}),
        .o_word    (step_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_word;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_word_valid = r_out.word_valid;
    assign o_is_data    = r_out.is_data;
    assign o_bus_word   = r_out.bus_word;
    assign o_last_word  = r_out.last_word;

endmodule : display_rect_fill_sequencer
`default_nettype wire
